// ===== rtl/lpfr_pkg.sv =====
// Package for the length-prefixed frame receiver.
// Holds the event codes, the result record and shared constants; no dependencies.
`timescale 1ns / 1ps

package lpfr_pkg;

    localparam int unsigned HEADER_BYTES = 3;
    localparam logic [15:0] MAX_BODY_RESET = 16'd8192;

    typedef enum logic [1:0] {
        EV_TAKEN    = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_DROPPED  = 2'd2
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic        body_valid;
        logic [7:0]  body_byte;
        logic [15:0] body_offset;
        logic [7:0]  message_key;
        logic [15:0] message_length;
        logic        last;
    } result_t;

endpackage

// ===== rtl/length_prefixed_frame_receiver.sv =====
// Top level of the length-prefixed frame receiver.
// Instantiates lpfr_parser and lpfr_out_reg; depends on lpfr_pkg.
//
// The input channel (in_valid, in_ready, data_byte) carries one stream byte
// per transaction. Each message is a key byte, a 16-bit little-endian total
// length that counts the three header bytes, and then the body bytes.
// The output channel (out_valid, out_ready and the result fields) carries
// exactly one result per input byte: an event code, the body byte with its
// offset when the byte belongs to a body, the message key and body length,
// and last on the byte that completes or drops a message.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// largest accepted body length; it is always ready and should be written
// only while no result is outstanding.
// The result of an input transaction is valid in the cycle after it, and one byte
// is taken every cycle while out_ready stays high; the parse state update
// and the single result register give this behaviour.
// When the receiver stalls, the result register holds its result and
// in_ready drops until that result is taken.
// Reset clears the parse state, empties the result register and sets the
// length limit to 8192.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic        body_valid,
    output logic [7:0]  body_byte,
    output logic [15:0] body_offset,
    output logic [7:0]  message_key,
    output logic [15:0] message_length,
    output logic        last
);

    logic              accept;
    logic              can_load;
    lpfr_pkg::result_t parse_result;
    lpfr_pkg::result_t out_result;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign accept    = in_valid && can_load;

    lpfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .result    (parse_result)
    );

    lpfr_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (parse_result),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .can_load   (can_load),
        .result_out (out_result)
    );

    assign event_res      = out_result.event_res;
    assign body_valid     = out_result.body_valid;
    assign body_byte      = out_result.body_byte;
    assign body_offset    = out_result.body_offset;
    assign message_key    = out_result.message_key;
    assign message_length = out_result.message_length;
    assign last           = out_result.last;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("Accepted byte produced no result.");

    a_last_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (event_res != lpfr_pkg::EV_TAKEN)))
        else $error("Last flag disagrees with event code.");

    a_event_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res != 2'd3))
        else $error("Undefined event code on output.");

    a_final_body_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_valid && last |->
            (body_offset == message_length - 16'd1))
        else $error("Final body byte offset does not match body length.");
`endif

endmodule

// ===== rtl/lpfr_parser.sv =====
// Header and body parser of the length-prefixed frame receiver.
// Holds the parse state and the length limit and forms the result of one byte.
// Depends on lpfr_pkg.
`timescale 1ns / 1ps

module lpfr_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               cfg_write,
    input  logic [15:0]        cfg_data,
    output lpfr_pkg::result_t  result
);

    localparam logic [15:0] HEADER_LEN = 16'(lpfr_pkg::HEADER_BYTES);

    logic        in_body_reg, in_body_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [7:0]  key_reg, key_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [15:0] body_count_reg, body_count_next;
    logic [15:0] max_body_reg;

    logic [15:0] total;
    logic [15:0] header_len;
    logic [15:0] count_inc;

    assign total      = {data_byte, length_low_reg};
    assign header_len = total - HEADER_LEN;
    assign count_inc  = body_count_reg + 16'd1;

    always_comb
    begin
        in_body_next      = in_body_reg;
        header_count_next = header_count_reg;
        key_next          = key_reg;
        length_low_next   = length_low_reg;
        body_length_next  = body_length_reg;
        body_count_next   = body_count_reg;

        result                = '0;
        result.event_res      = lpfr_pkg::EV_TAKEN;
        result.message_key    = key_reg;

        if (in_body_reg)
        begin
            result.body_valid     = 1'b1;
            result.body_byte      = data_byte;
            result.body_offset    = body_count_reg;
            result.message_length = body_length_reg;
            body_count_next       = count_inc;
            if (count_inc >= body_length_reg)
            begin
                result.event_res  = lpfr_pkg::EV_COMPLETE;
                result.last       = 1'b1;
                in_body_next      = 1'b0;
                header_count_next = 2'd0;
                body_count_next   = 16'd0;
            end
        end
        else if (header_count_reg == 2'd0)
        begin
            key_next           = data_byte;
            result.message_key = data_byte;
            header_count_next  = 2'd1;
        end
        else if (header_count_reg == 2'd1)
        begin
            length_low_next   = data_byte;
            header_count_next = 2'd2;
        end
        else
        begin
            result.message_length = header_len;
            header_count_next     = 2'd0;
            body_count_next       = 16'd0;
            if (total < HEADER_LEN || header_len > max_body_reg)
            begin
                result.event_res = lpfr_pkg::EV_DROPPED;
                result.last      = 1'b1;
            end
            else if (header_len == 16'd0)
            begin
                result.event_res = lpfr_pkg::EV_COMPLETE;
                result.last      = 1'b1;
            end
            else
            begin
                body_length_next = header_len;
                in_body_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg      <= 1'b0;
            header_count_reg <= 2'd0;
            key_reg          <= 8'd0;
            length_low_reg   <= 8'd0;
            body_length_reg  <= 16'd0;
            body_count_reg   <= 16'd0;
            max_body_reg     <= lpfr_pkg::MAX_BODY_RESET;
        end
        else
        begin
            if (accept)
            begin
                in_body_reg      <= in_body_next;
                header_count_reg <= header_count_next;
                key_reg          <= key_next;
                length_low_reg   <= length_low_next;
                body_length_reg  <= body_length_next;
                body_count_reg   <= body_count_next;
            end
            if (cfg_write)
            begin
                max_body_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== rtl/lpfr_out_reg.sv =====
// Result register of the length-prefixed frame receiver.
// Holds one finished result until the output transaction completes.
// Depends on lpfr_pkg.
`timescale 1ns / 1ps

module lpfr_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  lpfr_pkg::result_t  result_in,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               can_load,
    output lpfr_pkg::result_t  result_out
);

    logic              valid_reg;
    lpfr_pkg::result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= result_in;
        end
    end

endmodule

// ===== sim/length_prefixed_frame_receiver_tb.sv =====
// Self-checking testbench for length_prefixed_frame_receiver: drives framed byte streams,
// predicts every result in a scoreboard class and compares it field by field.
// Depends on lpfr_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_tb;

    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned BODY_CAP = 300;

    class frame_result_tracker;
        logic [15:0]         max_body;
        bit                  in_body;
        logic [1:0]          header_pos;
        logic [7:0]          key;
        logic [7:0]          length_lsb;
        logic [15:0]         body_len;
        logic [15:0]         body_pos;
        lpfr_pkg::result_t   pending_results[$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         completed;
        int unsigned         dropped;

        function new();
            max_body = lpfr_pkg::MAX_BODY_RESET;
            in_body = 1'b0;
            header_pos = '0;
            key = '0;
            length_lsb = '0;
            body_len = '0;
            body_pos = '0;
            errors = 0;
            checked = 0;
            completed = 0;
            dropped = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void set_max_body(logic [15:0] value);
            max_body = value;
        endfunction

        function void close_message(lpfr_pkg::event_t ev, ref lpfr_pkg::result_t r);
            r.event_res = ev;
            r.last = 1'b1;
            in_body = 1'b0;
            header_pos = '0;
            body_pos = '0;
            if (ev == lpfr_pkg::EV_COMPLETE)
                completed++;
            else
                dropped++;
        endfunction

        function void parse_byte(logic [7:0] b);
            lpfr_pkg::result_t r;
            logic [15:0]       total;
            r = '0;
            r.event_res = lpfr_pkg::EV_TAKEN;
            if (in_body)
            begin
                r.body_valid = 1'b1;
                r.body_byte = b;
                r.body_offset = body_pos;
                r.message_key = key;
                r.message_length = body_len;
                body_pos = body_pos + 16'd1;
                if (body_pos >= body_len)
                    close_message(lpfr_pkg::EV_COMPLETE, r);
            end
            else if (header_pos == 2'd0)
            begin
                key = b;
                r.message_key = b;
                header_pos = 2'd1;
            end
            else if (header_pos == 2'd1)
            begin
                length_lsb = b;
                r.message_key = key;
                header_pos = 2'd2;
            end
            else
            begin
                total = {b, length_lsb};
                r.message_key = key;
                r.message_length = total - 16'(lpfr_pkg::HEADER_BYTES);
                if (total < lpfr_pkg::HEADER_BYTES || r.message_length > max_body)
                    close_message(lpfr_pkg::EV_DROPPED, r);
                else if (r.message_length == 16'd0)
                    close_message(lpfr_pkg::EV_COMPLETE, r);
                else
                begin
                    body_len = r.message_length;
                    body_pos = '0;
                    in_body = 1'b1;
                    header_pos = '0;
                end
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
                report_mismatch($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                                          checked, name, want, got));
        endtask

        task compare_result(lpfr_pkg::result_t got);
            lpfr_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("event_res", want.event_res, got.event_res);
                check_field("body_valid", want.body_valid, got.body_valid);
                check_field("body_byte", want.body_byte, got.body_byte);
                check_field("body_offset", want.body_offset, got.body_offset);
                check_field("message_key", want.message_key, got.message_key);
                check_field("message_length", want.message_length, got.message_length);
                check_field("last", want.last, got.last);
            end
            checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  event_res;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [15:0] body_offset;
    logic [7:0]  message_key;
    logic [15:0] message_length;
    logic        last;

    frame_result_tracker tracker;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_sent;
    int unsigned limit_writes;

    length_prefixed_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .body_valid     (body_valid),
        .body_byte      (body_byte),
        .body_offset    (body_offset),
        .message_key    (message_key),
        .message_length (message_length),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        lpfr_pkg::result_t got;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.event_res = lpfr_pkg::event_t'(event_res);
                got.body_valid = body_valid;
                got.body_byte = body_byte;
                got.body_offset = body_offset;
                got.message_key = message_key;
                got.message_length = message_length;
                got.last = last;
                tracker.compare_result(got);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog expired after %0d cycles without a transaction.", IDLE_LIMIT);
        $display("length_prefixed_frame_receiver_tb failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.parse_byte(b);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic write_max_body(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_max_body(value);
        limit_writes++;
    endtask

    task automatic send_message(input int unsigned budget);
        int unsigned pick;
        int unsigned cap;
        int unsigned body_n;
        int unsigned cut;
        logic [15:0] total;
        pick = $urandom_range(99);
        cap = (tracker.max_body < BODY_CAP) ? tracker.max_body : BODY_CAP;
        body_n = 0;
        cut = 0;
        if (pick < 60)
        begin
            if ($urandom_range(7) == 0)
                body_n = cap;
            else if ($urandom_range(14) == 0)
                body_n = $urandom_range(cap);
            else
                body_n = $urandom_range((cap < 12) ? cap : 12);
            if (body_n + lpfr_pkg::HEADER_BYTES > budget)
                body_n = (budget > lpfr_pkg::HEADER_BYTES) ?
                         budget - lpfr_pkg::HEADER_BYTES : 0;
            total = 16'(body_n + lpfr_pkg::HEADER_BYTES);
        end
        else if (pick < 75 && tracker.max_body < 16'hFFFF - lpfr_pkg::HEADER_BYTES)
        begin
            total = 16'($urandom_range(16'hFFFF,
                                       tracker.max_body + lpfr_pkg::HEADER_BYTES + 1));
        end
        else if (pick < 88 || cap == 0 || tracker.max_body > BODY_CAP)
        begin
            total = 16'($urandom_range(lpfr_pkg::HEADER_BYTES - 1));
        end
        else
        begin
            // A header whose body is cut short, so the next bytes run into the body.
            body_n = $urandom_range(1, (cap < 12) ? cap : 12);
            cut = $urandom_range(1, body_n);
            total = 16'(body_n + lpfr_pkg::HEADER_BYTES);
        end
        send_byte(8'($urandom_range(255)));
        send_byte(total[7:0]);
        send_byte(total[15:8]);
        repeat (body_n - cut)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic run_phase(input logic [15:0] limit, input int unsigned send_pct,
                             input int unsigned stall_pct, input int unsigned carry,
                             input int unsigned n_items);
        int unsigned target;
        hold_until_drained();
        repeat (3)
            @(posedge clk);
        write_max_body(limit);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (carry)
            send_byte(8'($urandom_range(255)));
        target = bytes_sent + n_items;
        while (bytes_sent < target)
        begin
            if ($urandom_range(24) == 0)
                hold_until_drained();
            send_message(target - bytes_sent);
        end
    endtask

    initial
    begin
        logic [7:0] opening[] = '{
            8'hFF, 8'h03, 8'h00,
            8'h00, 8'h00, 8'h00,
            8'h55, 8'h01, 8'h00,
            8'hAA, 8'h02, 8'h00,
            8'h5A, 8'h05, 8'h00, 8'h00, 8'hFF,
            8'hC3, 8'h04, 8'h20,
            8'h81, 8'hFF, 8'hFF,
            8'h3C, 8'h09, 8'h00, 8'hA5, 8'h5A
        };
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        limit_writes = 0;
        tracker = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The last opening message is left in its body; the limit drops to zero
        // before the rest of that body arrives.
        foreach (opening[i])
            send_byte(opening[i]);

        run_phase(16'd0, 86, 0, 4, 90);
        run_phase(16'hFFFF, 0, 86, 0, 90);
        run_phase(16'd12, 33, 33, 0, 90);
        run_phase(16'd300, 0, 0, 0, 90);
        run_phase(16'd1, 0, 86, 0, 90);

        hold_until_drained();
        repeat (4)
            @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                              tracker.pending()));

        $display("Sent %0d stream bytes under %0d length limits; checked %0d results.",
                 bytes_sent, limit_writes + 1, tracker.checked);
        $display("Messages completed: %0d, dropped: %0d, mismatches: %0d.",
                 tracker.completed, tracker.dropped, tracker.errors);
        if (tracker.errors == 0)
            $display("length_prefixed_frame_receiver_tb passed");
        else
            $display("length_prefixed_frame_receiver_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lpfr_pkg.sv
rtl/lpfr_parser.sv
rtl/lpfr_out_reg.sv
rtl/length_prefixed_frame_receiver.sv
sim/length_prefixed_frame_receiver_tb.sv
